### src/gcrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcrc_pkg
// shared types, constants and code tables of the 4-to-5 gcr codec
// ----------------------------------------------------------------------------
package gcrc_pkg;

  localparam int unsigned GrpData  = 4;   // data bytes in one group
  localparam int unsigned GrpCode  = 5;   // code bytes in one group
  localparam int unsigned CntW     = 3;   // width of byte counts

  // mode register values
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  // one loaded burst of results, handed from collector to emitter
  typedef struct packed {
    logic [GrpCode-1:0][7:0] bytes;   // entry 0 goes out first
    logic [CntW-1:0]         count;   // number of results, 0 means none
    logic [1:0]              status;
  } burst_t;

  // nibble to 5-bit code
  function automatic logic [4:0] nib_to_code(input logic [3:0] nib);
    logic [4:0] c;
    case (nib)
      4'h0: c = 5'h0A;
      4'h1: c = 5'h0B;
      4'h2: c = 5'h12;
      4'h3: c = 5'h13;
      4'h4: c = 5'h0E;
      4'h5: c = 5'h0F;
      4'h6: c = 5'h16;
      4'h7: c = 5'h17;
      4'h8: c = 5'h09;
      4'h9: c = 5'h19;
      4'hA: c = 5'h1A;
      4'hB: c = 5'h1B;
      4'hC: c = 5'h0D;
      4'hD: c = 5'h1D;
      4'hE: c = 5'h1E;
      default: c = 5'h15;
    endcase
    return c;
  endfunction

  // 5-bit code to {invalid flag, nibble}
  function automatic logic [4:0] code_to_nib(input logic [4:0] code);
    logic [4:0] r;
    case (code)
      5'h0A: r = 5'h00;
      5'h0B: r = 5'h01;
      5'h12: r = 5'h02;
      5'h13: r = 5'h03;
      5'h0E: r = 5'h04;
      5'h0F: r = 5'h05;
      5'h16: r = 5'h06;
      5'h17: r = 5'h07;
      5'h09: r = 5'h08;
      5'h19: r = 5'h09;
      5'h1A: r = 5'h0A;
      5'h1B: r = 5'h0B;
      5'h0D: r = 5'h0C;
      5'h1D: r = 5'h0D;
      5'h1E: r = 5'h0E;
      5'h15: r = 5'h0F;
      default: r = 5'h10;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### src/gcr_4_to_5_codec.sv
`timescale 1ns / 1ps
`default_nettype none
// a completing word shows its first result in the cycle after its acceptance
// throughput: one word per cycle while a group fills; the word that completes a
//   group waits until the previous burst has drained
// reset: asynchronous active-low clears mode (encode), group count and burst
// ----------------------------------------------------------------------------
// gcr_4_to_5_codec
// 4-to-5 group code recording codec: collects a group of words, converts it
// through the nibble code tables and streams results one word per unstalled cycle
// ----------------------------------------------------------------------------
module gcr_4_to_5_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  // config write channel, mode register
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_mode_i,
  // input word channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  // result word channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       last_of_group_o
);
  import gcrc_pkg::*;

  logic   mode_q;
  logic   cfg_wr;
  logic   busy;
  burst_t load;

  // mode writes are always taken; a write also drops any partial group
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENCODE;
    end else if (cfg_wr) begin
      mode_q <= cfg_mode_i;
    end
  end

  // input register stage: group bytes plus the table lookup logic
  gcrc_collect u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .clear_i     (cfg_wr),
    .busy_i      (busy),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .in_stall_o  (in_stall_o),
    .load_o      (load)
  );

  // result register stage: drains a burst of up to five words
  gcrc_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .busy_o          (busy),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .status_o        (status_o),
    .last_of_group_o (last_of_group_o)
  );

endmodule
`default_nettype wire

### src/gcrc_collect.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcrc_collect
// gathers group bytes and forms the encoded or decoded burst of a full group
// ----------------------------------------------------------------------------
module gcrc_collect (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            mode_i,
  input  logic            clear_i,
  input  logic            busy_i,
  input  logic            in_valid_i,
  input  logic [7:0]      data_byte_i,
  input  logic            last_byte_i,
  output logic            in_stall_o,
  output gcrc_pkg::burst_t load_o
);
  import gcrc_pkg::*;

  logic [GrpData-1:0][7:0] buf_q;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    done;
  logic                    accept;
  logic [GrpData-1:0][7:0] dbytes;
  logic [39:0]             enc_bits;
  logic [39:0]             dec_bits;
  logic [4:0]              dec_r [8];
  logic                    bad;
  burst_t                  load;

  // group completes with this word
  always_comb begin
    if (mode_i == MODE_DECODE) begin
      done = (cnt_q == CntW'(GrpCode - 1)) || last_byte_i;
    end else begin
      done = (cnt_q == CntW'(GrpData - 1)) || last_byte_i;
    end
  end

  assign in_stall_o = busy_i && done;
  assign accept     = in_valid_i && !in_stall_o;

  // encode: missing bytes of a short group read as zero
  always_comb begin
    for (int i = 0; i < GrpData; i++) begin
      if (CntW'(i) < cnt_q) begin
        dbytes[i] = buf_q[i];
      end else if (CntW'(i) == cnt_q) begin
        dbytes[i] = data_byte_i;
      end else begin
        dbytes[i] = 8'h00;
      end
    end
    for (int i = 0; i < GrpData; i++) begin
      enc_bits[39 - 10*i -: 5] = nib_to_code(dbytes[i][7:4]);
      enc_bits[34 - 10*i -: 5] = nib_to_code(dbytes[i][3:0]);
    end
  end

  // decode: eight codes from the four held bytes and the current one
  always_comb begin
    dec_bits = {buf_q[0], buf_q[1], buf_q[2], buf_q[3], data_byte_i};
    bad      = 1'b0;
    for (int i = 0; i < 8; i++) begin
      dec_r[i] = code_to_nib(dec_bits[39 - 5*i -: 5]);
      bad      = bad | dec_r[i][4];
    end
  end

  always_comb begin
    load = '0;
    if (accept && done) begin
      if (mode_i == MODE_ENCODE) begin
        for (int i = 0; i < GrpCode; i++) begin
          load.bytes[i] = enc_bits[39 - 8*i -: 8];
        end
        load.count  = CntW'(GrpCode);
        load.status = ST_OK;
      end else if (cnt_q != CntW'(GrpCode - 1)) begin
        load.count  = CntW'(1);
        load.status = ST_SHORT;
      end else if (bad) begin
        load.count  = CntW'(1);
        load.status = ST_BAD;
      end else begin
        for (int i = 0; i < GrpData; i++) begin
          load.bytes[i] = {dec_r[2*i][3:0], dec_r[2*i+1][3:0]};
        end
        load.count  = CntW'(GrpData);
        load.status = ST_OK;
      end
    end
  end

  assign load_o = load;

  always_comb begin
    cnt_d = cnt_q;
    if (clear_i) begin
      cnt_d = '0;
    end else if (accept) begin
      cnt_d = done ? '0 : cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // held bytes, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && !done) begin
      buf_q[cnt_q[1:0]] <= data_byte_i;
    end
  end

endmodule
`default_nettype wire

### src/gcrc_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcrc_emit
// result register that shifts one burst out a word per cycle unless the output is stalled
// ----------------------------------------------------------------------------
module gcrc_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gcrc_pkg::burst_t load_i,
  output logic            busy_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      status_o,
  output logic            last_of_group_o
);
  import gcrc_pkg::*;

  logic [GrpCode-1:0][7:0] bytes_q, bytes_d;
  logic [CntW-1:0]         rem_q, rem_d;
  logic [1:0]              status_q, status_d;
  logic                    take;

  assign busy_o          = (rem_q != '0);
  assign out_valid_o     = busy_o;
  assign take            = busy_o && !out_stall_i;
  assign out_byte_o      = bytes_q[0];
  assign status_o        = status_q;
  assign last_of_group_o = (rem_q == CntW'(1));

  always_comb begin
    bytes_d  = bytes_q;
    rem_d    = rem_q;
    status_d = status_q;
    if (load_i.count != '0) begin
      bytes_d  = load_i.bytes;
      rem_d    = load_i.count;
      status_d = load_i.status;
    end else if (take) begin
      for (int i = 0; i < GrpCode - 1; i++) begin
        bytes_d[i] = bytes_q[i+1];
      end
      bytes_d[GrpCode-1] = 8'h00;
      rem_d = rem_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q  <= bytes_d;
    status_q <= status_d;
  end

endmodule
`default_nettype wire
